/* rtl/stt_pkg.sv */
package stt_pkg;

  localparam int KEY_W   = 64;
  localparam int MOVE_W  = 25;
  localparam int SCORE_W = 16;
  localparam int DEPTH_W = 6;
  localparam int BOUND_W = 2;
  localparam int AGE_W   = 8;
  localparam int THR_W   = 15;
  localparam int PLY_W   = 6;
  localparam int OP_W    = 2;
  localparam int CNT_W   = 32;

  localparam int S_TDATA_W  = 152;
  localparam int M_TDATA_W  = 144;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index sits in this address bit (registers at 4*i)
  localparam int REG_IDX_BIT = 2;
  localparam logic REG_AGE = 1'b0;
  localparam logic REG_THR = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = 15'd29936;

  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_BEST  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [AGE_W-1:0]          age;
    logic [BOUND_W-1:0]        bound;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
  } entry_t;

  typedef struct packed {
    op_t                       op;
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
    logic [PLY_W-1:0]          ply;
  } item_t;

  typedef struct packed {
    logic                      cutoff;
    logic signed [SCORE_W-1:0] score;
    logic                      move_valid;
    logic [MOVE_W-1:0]         move;
    logic                      hit;
    logic                      new_write;
    logic                      over_write;
    logic                      wr_en;
  } calc_res_t;

  // shift a mate score by ply: away from zero on store, towards zero on probe
  function automatic logic signed [SCORE_W-1:0] mate_adjust(
    input logic signed [SCORE_W-1:0] s,
    input logic [PLY_W-1:0]          ply,
    input logic [THR_W-1:0]          thr,
    input logic                      is_store
  );
    logic signed [17:0] s_x;
    logic signed [17:0] thr_x;
    logic signed [17:0] ply_x;
    logic signed [17:0] sum;
    logic signed [SCORE_W-1:0] res;
    s_x   = 18'(s);
    thr_x = signed'({3'b000, thr});
    ply_x = signed'({12'd0, ply});
    sum   = s_x;
    if (s_x > thr_x) begin
      sum = is_store ? s_x + ply_x : s_x - ply_x;
    end else if (s_x < -thr_x) begin
      sum = is_store ? s_x - ply_x : s_x + ply_x;
    end
    if (sum > 18'sd32767) begin
      res = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = 16'(sum);
    end
    return res;
  endfunction

endpackage

/* rtl/stt_ram.sv */
module stt_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 121
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/stt_calc.sv */
module stt_calc (
  input  stt_pkg::item_t                   item,
  input  stt_pkg::entry_t                  entry,
  input  logic [stt_pkg::AGE_W-1:0]        age,
  input  logic [stt_pkg::THR_W-1:0]        thr,
  output stt_pkg::calc_res_t               res,
  output stt_pkg::entry_t                  wr_entry
);

  logic                               match;
  logic                               deep;
  logic signed [stt_pkg::SCORE_W-1:0] adj;

  always_comb begin
    match = (item.key != '0) && (entry.key == item.key);
    deep  = entry.depth >= item.depth;
    adj   = stt_pkg::mate_adjust(entry.score, item.ply, thr, 1'b0);

    wr_entry.key   = item.key;
    wr_entry.age   = age;
    wr_entry.bound = item.bound;
    wr_entry.depth = item.depth;
    wr_entry.score = stt_pkg::mate_adjust(item.score, item.ply, thr, 1'b1);
    wr_entry.move  = item.move;

    res = '0;
    unique case (item.op)
      stt_pkg::OP_PROBE: begin
        if (match) begin
          res.move_valid = 1'b1;
          res.move       = entry.move;
          if (deep) begin
            res.hit   = 1'b1;
            res.score = adj;
            unique case (entry.bound)
              stt_pkg::BOUND_UPPER: begin
                if (adj <= item.alpha) begin
                  res.score  = item.alpha;
                  res.cutoff = 1'b1;
                end
              end
              stt_pkg::BOUND_LOWER: begin
                if (adj >= item.beta) begin
                  res.score  = item.beta;
                  res.cutoff = 1'b1;
                end
              end
              stt_pkg::BOUND_EXACT: res.cutoff = 1'b1;
              default: ;
            endcase
          end
        end
      end
      stt_pkg::OP_STORE: begin
        if (item.key != '0) begin
          if (entry.key == '0) begin
            res.new_write = 1'b1;
            res.wr_en     = 1'b1;
          end else if ((entry.age < age) ||
                       ((entry.age == age) && (entry.depth < item.depth))) begin
            res.over_write = 1'b1;
            res.wr_en      = 1'b1;
          end
        end
      end
      stt_pkg::OP_BEST: begin
        if (match) begin
          res.move_valid = 1'b1;
          res.move       = entry.move;
        end
      end
      stt_pkg::OP_CLEAR: ;
    endcase
  end

endmodule

/* rtl/search_transposition_table.sv */
// An accepted item is evaluated in ST_EVAL; its result is registered into the output stage
// on the commit, which waits while an earlier result still waits for m_axis_tready.
// One item at a time, s_axis_tready low until it commits: a table read, then decision and write-back.
// A clear is followed by a sweep over all TABLE_ENTRIES entries, one entry written per cycle.
// Reset (rst, synchronous, active high) clears the counters and age and loads thr with THR_RESET,
// then a sweep empties all TABLE_ENTRIES entries; s_axis_tready stays low until it ends.
module search_transposition_table #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // key, move_in, score_in, bound_type, search_depth, alpha, beta, ply
  input  logic [stt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // op
  input  logic [stt_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // cutoff, score_out, move_out, hit_count, new_write_count, over_write_count
  output logic [stt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // move_valid
  output logic                             m_axis_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [stt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [stt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int ENTRY_W = $bits(stt_pkg::entry_t);

  stt_pkg::state_t    state, state_next;
  stt_pkg::item_t     item_in, item;
  stt_pkg::entry_t    rd_entry, wr_entry;
  stt_pkg::calc_res_t res;

  logic [IDX_W-1:0]               sweep;
  logic [stt_pkg::AGE_W-1:0]      age;
  logic [stt_pkg::THR_W-1:0]      thr;
  logic [stt_pkg::CNT_W-1:0]      hits, new_writes, over_writes;
  logic                           commit, sweep_wr, accept, cfg_wr;
  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic [ENTRY_W-1:0]             ram_wdata, ram_rdata;

  logic                              out_valid;
  logic                              out_cutoff;
  logic signed [stt_pkg::SCORE_W-1:0] out_score;
  logic                              out_move_valid;
  logic [stt_pkg::MOVE_W-1:0]        out_move;

  always_comb begin
    item_in.op    = stt_pkg::op_t'(s_axis_tuser);
    item_in.key   = s_axis_tdata[63:0];
    item_in.move  = s_axis_tdata[88:64];
    item_in.score = s_axis_tdata[104:89];
    item_in.bound = s_axis_tdata[106:105];
    item_in.depth = s_axis_tdata[112:107];
    item_in.alpha = s_axis_tdata[128:113];
    item_in.beta  = s_axis_tdata[144:129];
    item_in.ply   = s_axis_tdata[150:145];
  end

  assign s_axis_tready = (state == stt_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stt_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    commit     = 1'b0;
    sweep_wr   = 1'b0;
    unique case (state)
      stt_pkg::ST_SWEEP: begin
        sweep_wr = 1'b1;
        if (sweep == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_next = stt_pkg::ST_IDLE;
        end
      end
      stt_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = stt_pkg::ST_EVAL;
        end
      end
      stt_pkg::ST_EVAL: begin
        if (!out_valid || m_axis_tready) begin
          commit     = 1'b1;
          state_next = (item.op == stt_pkg::OP_CLEAR) ? stt_pkg::ST_SWEEP : stt_pkg::ST_IDLE;
        end
      end
      default: state_next = stt_pkg::ST_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
  end

  // wraps back to zero at the end of each sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (sweep_wr) begin
      sweep <= sweep + 1'b1;
    end
  end

  assign rd_entry  = stt_pkg::entry_t'(ram_rdata);
  assign ram_we    = sweep_wr || (commit && res.wr_en);
  assign ram_waddr = sweep_wr ? sweep : item.key[IDX_W-1:0];
  assign ram_wdata = sweep_wr ? '0 : ENTRY_W'(wr_entry);

  stt_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (item_in.key[IDX_W-1:0]),
    .rd_data (ram_rdata),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata)
  );

  stt_calc u_calc (
    .item     (item),
    .entry    (rd_entry),
    .age      (age),
    .thr      (thr),
    .res      (res),
    .wr_entry (wr_entry)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[stt_pkg::REG_IDX_BIT] == stt_pkg::REG_AGE) begin
      prdata = {{(stt_pkg::CFG_DATA_W - stt_pkg::AGE_W){1'b0}}, age};
    end else begin
      prdata = {{(stt_pkg::CFG_DATA_W - stt_pkg::THR_W){1'b0}}, thr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age         <= '0;
      thr         <= stt_pkg::THR_RESET;
      hits        <= '0;
      new_writes  <= '0;
      over_writes <= '0;
    end else begin
      if (commit) begin
        hits        <= hits + stt_pkg::CNT_W'(res.hit);
        over_writes <= over_writes + stt_pkg::CNT_W'(res.over_write);
        if (item.op == stt_pkg::OP_CLEAR) begin
          new_writes <= '0;
          age        <= '0;
        end else begin
          new_writes <= new_writes + stt_pkg::CNT_W'(res.new_write);
        end
      end
      if (cfg_wr) begin
        if (paddr[stt_pkg::REG_IDX_BIT] == stt_pkg::REG_AGE) begin
          age <= pwdata[stt_pkg::AGE_W-1:0];
        end else begin
          thr <= pwdata[stt_pkg::THR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_cutoff     <= res.cutoff;
      out_score      <= res.score;
      out_move_valid <= res.move_valid;
      out_move       <= res.move;
    end
  end

  // counters only move on a commit, which also reloads the output stage
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_move_valid;
  assign m_axis_tdata  = {6'd0, over_writes, new_writes, hits, out_move, out_score, out_cutoff};

endmodule

/* rtl/stt_checker.sv */
module stt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [stt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [stt_pkg::CFG_ADDR_W-1:0]   paddr,
  input logic [stt_pkg::CFG_DATA_W-1:0]   pwdata,
  input logic [stt_pkg::CFG_DATA_W-1:0]   prdata,
  input logic                             pready
);

  // reset empties the output and starts the table sweep
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("output valid or input ready right after reset");

  // one item at a time: no transfer in the cycle after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready in the cycle after a transfer");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result dropped or changed");

  // an age write reads back in the following cycle
  a_age_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[stt_pkg::REG_IDX_BIT] == stt_pkg::REG_AGE)
    |=> (paddr[stt_pkg::REG_IDX_BIT] != stt_pkg::REG_AGE) ||
        (prdata == {24'd0, $past(pwdata[stt_pkg::AGE_W-1:0])}))
    else $error("age register readback mismatch");

endmodule

bind search_transposition_table stt_checker u_stt_checker (.*);

/* verif/search_transposition_table_checker.sv */
`timescale 1ns / 1ps

module search_transposition_table_checker #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // key, move_in, score_in, bound_type, search_depth, alpha, beta, ply
  input  logic [stt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [stt_pkg::OP_W-1:0]       s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // cutoff, score_out, move_out, hit_count, new_write_count, over_write_count
  input  logic [stt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // move_valid
  input  logic                           m_axis_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [stt_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [stt_pkg::CFG_DATA_W-1:0] prdata,
  input  logic                           pready,
  output int                             failures,
  output int                             outstanding
);

  import stt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  typedef struct {
    bit              cutoff;
    int              score;
    bit              move_valid;
    bit [MOVE_W-1:0] move;
    bit [CNT_W-1:0]  hits;
    bit [CNT_W-1:0]  new_writes;
    bit [CNT_W-1:0]  over_writes;
  } reply_t;

  entry_t         slots [TABLE_ENTRIES];
  bit [CNT_W-1:0] hit_total;
  bit [CNT_W-1:0] new_total;
  bit [CNT_W-1:0] over_total;
  bit [AGE_W-1:0] age_reg;
  bit [THR_W-1:0] thr_reg;
  reply_t         pending_replies [$];
  reply_t         want;
  int             fail_count = 0;

  function automatic void wipe_slots();
    for (int i = 0; i < TABLE_ENTRIES; i++) slots[i] = '0;
  endfunction

  // push a mate score away from zero on a store, towards zero on a probe
  function automatic int shift_mate(int s, int ply, bit storing);
    int t;
    int v;
    t = int'(thr_reg);
    v = s;
    if (s > t) begin
      v = storing ? s + ply : s - ply;
    end else if (s < -t) begin
      v = storing ? s - ply : s + ply;
    end
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic reply_t apply_op(op_t op, logic [S_TDATA_W-1:0] d);
    bit [KEY_W-1:0]   key;
    bit [MOVE_W-1:0]  mv;
    bit [BOUND_W-1:0] bound;
    int               score;
    int               depth;
    int               alpha;
    int               beta;
    int               ply;
    int               idx;
    int               s;
    entry_t           e;
    bit               matched;
    bit               replace;
    reply_t           r;
    key     = d[63:0];
    mv      = d[88:64];
    score   = int'($signed(d[104:89]));
    bound   = d[106:105];
    depth   = int'(d[112:107]);
    alpha   = int'($signed(d[128:113]));
    beta    = int'($signed(d[144:129]));
    ply     = int'(d[150:145]);
    idx     = int'(key[IDX_W-1:0]);
    e       = slots[idx];
    matched = (key != '0) && (e.key == key);
    r       = '{default: 0};
    case (op)
      OP_PROBE: begin
        if (matched) begin
          r.move_valid = 1'b1;
          r.move = e.move;
          if (int'(e.depth) >= depth) begin
            hit_total++;
            s = shift_mate(int'($signed(e.score)), ply, 1'b0);
            case (e.bound)
              BOUND_UPPER: begin
                if (s <= alpha) begin
                  s = alpha;
                  r.cutoff = 1'b1;
                end
              end
              BOUND_LOWER: begin
                if (s >= beta) begin
                  s = beta;
                  r.cutoff = 1'b1;
                end
              end
              BOUND_EXACT: r.cutoff = 1'b1;
              default: ;
            endcase
            r.score = s;
          end
        end
      end
      OP_STORE: begin
        if (key != '0) begin
          replace = 1'b0;
          if (e.key == '0) begin
            new_total++;
            replace = 1'b1;
          end else if (e.age < age_reg || (e.age == age_reg && int'(e.depth) < depth)) begin
            over_total++;
            replace = 1'b1;
          end
          if (replace) begin
            slots[idx] = '{key: key, age: age_reg, bound: bound, depth: DEPTH_W'(depth),
                           score: SCORE_W'(shift_mate(score, ply, 1'b1)), move: mv};
          end
        end
      end
      OP_BEST: begin
        if (matched) begin
          r.move_valid = 1'b1;
          r.move = e.move;
        end
      end
      default: begin
        wipe_slots();
        new_total = '0;
        age_reg = '0;
      end
    endcase
    r.hits        = hit_total;
    r.new_writes  = new_total;
    r.over_writes = over_total;
    return r;
  endfunction

  function automatic void compare_field(string name, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      wipe_slots();
      hit_total = '0;
      new_total = '0;
      over_total = '0;
      age_reg = '0;
      thr_reg = THR_RESET;
      pending_replies.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[REG_IDX_BIT] == REG_THR) thr_reg = pwdata[THR_W-1:0];
          else age_reg = pwdata[AGE_W-1:0];
        end else if (paddr[REG_IDX_BIT] == REG_THR) begin
          compare_field("prdata", longint'(thr_reg), longint'(prdata));
        end else begin
          compare_field("prdata", longint'(age_reg), longint'(prdata));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_replies.push_back(apply_op(op_t'(s_axis_tuser), s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_replies.size() == 0) begin
          $error("result transfer with no expectation waiting");
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          compare_field("cutoff", longint'(want.cutoff), longint'(m_axis_tdata[0]));
          compare_field("score_out", longint'(want.score), longint'($signed(m_axis_tdata[16:1])));
          compare_field("move_valid", longint'(want.move_valid), longint'(m_axis_tuser));
          compare_field("move_out", longint'(want.move), longint'(m_axis_tdata[41:17]));
          compare_field("hit_count", longint'(want.hits), longint'(m_axis_tdata[73:42]));
          compare_field("new_write_count", longint'(want.new_writes),
                        longint'(m_axis_tdata[105:74]));
          compare_field("over_write_count", longint'(want.over_writes),
                        longint'(m_axis_tdata[137:106]));
        end
      end
    end
    failures <= fail_count;
    outstanding <= pending_replies.size();
  end

endmodule

/* verif/search_transposition_table_test.sv */
`timescale 1ns / 1ps

module search_transposition_table_test;

  import stt_pkg::*;

  localparam int ENTRIES       = 4096;
  localparam int IDX_W         = $clog2(ENTRIES);
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = ENTRIES + 16;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 313;
  localparam int IDX_POOL      = 16;
  localparam int KEY_POOL      = 40;

  localparam logic [BOUND_W-1:0]    BOUND_NONE = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_AGE   = CFG_ADDR_W'(REG_AGE) << REG_IDX_BIT;
  localparam logic [CFG_ADDR_W-1:0] ADDR_THR   = CFG_ADDR_W'(REG_THR) << REG_IDX_BIT;

  localparam logic [KEY_W-1:0] KEY_A = 64'hA5A5_0000_0000_0123;
  localparam logic [KEY_W-1:0] KEY_B = 64'h5A5A_0000_0000_0123;
  localparam logic [KEY_W-1:0] KEY_C = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_D = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] KEY_E = 64'h0123_4567_89AB_C456;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [OP_W-1:0]        s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  int                     failures;
  int                     outstanding;
  int                     quiet_cycles = 0;
  int                     cur_thr = int'(THR_RESET);
  bit                     calm_sender = 1'b0;
  bit                     calm_sink = 1'b0;
  int                     sink_hold = 0;
  int                     sink_roll;
  logic [IDX_W-1:0]       idx_pool [IDX_POOL];
  logic [KEY_W-1:0]       key_pool [KEY_POOL];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  search_transposition_table #(
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  search_transposition_table_checker #(
    .TABLE_ENTRIES(ENTRIES)
  ) table_check (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .failures(failures),
    .outstanding(outstanding)
  );

  // result side back-pressure: short stalls mostly, the odd long one, calm stretches
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      sink_roll = $urandom_range(0, 99);
      if (!calm_sink && sink_roll < 25) begin
        sink_hold <= (sink_roll < 2) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      end
    end
    if ($urandom_range(0, 199) == 0) calm_sink <= !calm_sink;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t make_item(op_t op, logic [KEY_W-1:0] key, logic [MOVE_W-1:0] mv,
                                      int score, logic [BOUND_W-1:0] bound, int depth,
                                      int alpha, int beta, int ply);
    item_t it;
    it.op    = op;
    it.key   = key;
    it.move  = mv;
    it.score = SCORE_W'(score);
    it.bound = bound;
    it.depth = DEPTH_W'(depth);
    it.alpha = SCORE_W'(alpha);
    it.beta  = SCORE_W'(beta);
    it.ply   = PLY_W'(ply);
    return it;
  endfunction

  // mostly keys that share a handful of slots, so probes and replacements meet
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      k = key_pool[$urandom_range(0, KEY_POOL-1)];
    end else if (r < 93) begin
      k = {$urandom, $urandom};
    end else if (r < 96) begin
      k = '0;
    end else begin
      k = '0;
      k[IDX_W-1:0] = idx_pool[$urandom_range(0, IDX_POOL-1)];
    end
    return k;
  endfunction

  // mix of random scores and ones clustered around the mate threshold, zero and the range limits
  function automatic int pick_score();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      v = int'($signed(16'($urandom)));
    end else if (r < 70) begin
      v = cur_thr + int'($urandom_range(0, 140)) - 70;
      if ($urandom_range(0, 1) == 1) v = -v;
    end else if (r < 85) begin
      v = int'($urandom_range(0, 1000)) - 500;
    end else begin
      case ($urandom_range(0, 4))
        0: v = -32768;
        1: v = -32767;
        2: v = 32767;
        3: v = 32766;
        default: v = 0;
      endcase
    end
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic item_t random_item();
    int r;
    op_t op;
    logic [BOUND_W-1:0] bound;
    r = $urandom_range(0, 999);
    op = (r < 420) ? OP_PROBE : (r < 820) ? OP_STORE : (r < 995) ? OP_BEST : OP_CLEAR;
    bound = ($urandom_range(0, 9) == 0) ? BOUND_NONE : BOUND_W'($urandom_range(0, 2));
    return make_item(op, pick_key(), MOVE_W'($urandom), pick_score(), bound,
                     $urandom_range(0, 63), pick_score(), pick_score(), $urandom_range(0, 63));
  endfunction

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 49) == 0) calm_sender = !calm_sender;
    if (calm_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  task automatic transfer_item(input item_t it);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.ply, it.beta, it.alpha, it.depth, it.bound, it.score,
                      it.move, it.key};
    s_axis_tuser  <= it.op;
    do @(posedge clk); while (!s_axis_tready);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic apb_access(input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data, input logic wr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every result is back and any table sweep has finished
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [KEY_W-1:0] k;
    int age_set;
    int thr_set;
    for (int i = 0; i < IDX_POOL; i++) begin
      idx_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : IDX_W'($urandom_range(0, ENTRIES-1));
    end
    for (int i = 0; i < KEY_POOL; i++) begin
      k = {$urandom, $urandom};
      k[IDX_W-1:0] = idx_pool[i % IDX_POOL];
      if (k == '0) k[KEY_W-1] = 1'b1;
      key_pool[i] = k;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    apb_access(ADDR_AGE, '0, 1'b0);
    apb_access(ADDR_THR, '0, 1'b0);
    apb_access(ADDR_AGE, '0, 1'b1);
    apb_access(ADDR_THR, CFG_DATA_W'(THR_RESET), 1'b1);

    transfer_item(make_item(OP_PROBE, KEY_A, '0, 0, BOUND_EXACT, 0, 0, 0, 0));
    transfer_item(make_item(OP_STORE, '0, '1, 5, BOUND_EXACT, 9, 0, 0, 0));
    transfer_item(make_item(OP_PROBE, '0, '0, 0, BOUND_EXACT, 0, 0, 0, 0));
    transfer_item(make_item(OP_STORE, KEY_A, '1, 32767, BOUND_EXACT, 10, 0, 0, 63));
    transfer_item(make_item(OP_PROBE, KEY_A, '0, 0, BOUND_EXACT, 10, 0, 0, 63));
    transfer_item(make_item(OP_PROBE, KEY_A, '0, 0, BOUND_EXACT, 11, 0, 0, 0));
    transfer_item(make_item(OP_BEST, KEY_A, '0, 0, BOUND_EXACT, 0, 0, 0, 0));
    transfer_item(make_item(OP_STORE, KEY_B, 25'h0AAAAAA, 1, BOUND_UPPER, 5, 0, 0, 0));
    transfer_item(make_item(OP_STORE, KEY_B, 25'h1555555, 0, BOUND_UPPER, 20, 0, 0, 0));
    transfer_item(make_item(OP_PROBE, KEY_A, '0, 0, BOUND_EXACT, 0, 0, 0, 0));
    transfer_item(make_item(OP_STORE, KEY_C, '0, -32768, BOUND_UPPER, 63, 0, 0, 63));
    transfer_item(make_item(OP_PROBE, KEY_C, '0, 0, BOUND_EXACT, 0, 32767, 0, 63));
    transfer_item(make_item(OP_PROBE, KEY_C, '0, 0, BOUND_EXACT, 63, -32768, 0, 0));
    transfer_item(make_item(OP_PROBE, KEY_C, '0, 0, BOUND_EXACT, 63, -32768, 0, 63));
    transfer_item(make_item(OP_STORE, KEY_D, 25'h0000001, 1000, BOUND_LOWER, 0, 0, 0, 0));
    transfer_item(make_item(OP_PROBE, KEY_D, '0, 0, BOUND_EXACT, 0, 0, -32768, 0));
    transfer_item(make_item(OP_PROBE, KEY_D, '0, 0, BOUND_EXACT, 0, 0, 32767, 0));
    transfer_item(make_item(OP_STORE, KEY_E, 25'h1000000, -29937, BOUND_NONE, 30, 0, 0, 1));
    transfer_item(make_item(OP_PROBE, KEY_E, '0, 0, BOUND_EXACT, 30, -32768, 32767, 5));
    transfer_item(make_item(OP_BEST, KEY_C, '0, 0, BOUND_EXACT, 0, 0, 0, 0));
    transfer_item(make_item(OP_CLEAR, '0, '0, 0, BOUND_EXACT, 0, 0, 0, 0));
    transfer_item(make_item(OP_PROBE, KEY_B, '0, 0, BOUND_EXACT, 0, 0, 0, 0));
    transfer_item(make_item(OP_BEST, KEY_C, '0, 0, BOUND_EXACT, 0, 0, 0, 0));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin age_set = 5;   thr_set = int'(THR_RESET); end
        1: begin age_set = 255; thr_set = 0;              end
        2: begin age_set = 3;   thr_set = 32767;          end
        3: begin age_set = 128; thr_set = 100;            end
        4: begin age_set = 0;   thr_set = 16384;          end
        default: begin age_set = 254; thr_set = 20000;    end
      endcase
      drain_and_settle();
      apb_access(ADDR_AGE, '0, 1'b0);
      apb_access(ADDR_AGE, CFG_DATA_W'(age_set), 1'b1);
      apb_access(ADDR_THR, CFG_DATA_W'(thr_set), 1'b1);
      apb_access(ADDR_AGE, '0, 1'b0);
      apb_access(ADDR_THR, '0, 1'b0);
      cur_thr = thr_set;
      for (int n = 0; n < PHASE_ITEMS; n++) transfer_item(random_item());
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (16) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
